// ===== design/ptb_pkg.sv =====
// Shared types and constants for the palindromic tree builder.
// Holds the transaction structs of both channels and the default sizes.
// No dependencies.
package ptb_pkg;

  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 26;
  localparam int OUT_W        = 11;
  localparam int SYM_W        = 5;

  localparam logic KIND_CLEAR  = 1'b0;
  localparam logic KIND_APPEND = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [SYM_W-1:0] symbol;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0] suffix_node;
    logic [OUT_W-1:0] pal_length;
    logic             is_new;
    logic [OUT_W-1:0] end_count;
    logic [OUT_W-1:0] suffix_depth;
    logic [OUT_W-1:0] length_step;
    logic [OUT_W-1:0] series_node;
    logic             refused;
  } result_t;

endpackage

// ===== design/palindromic_tree_builder.sv =====
// Top level of the palindromic tree builder.
// Depends on ptb_pkg for the transaction structs and default sizes.
//
// Usage: each input transaction either clears the tree to its two roots or
// appends one symbol. Every input transaction yields exactly one result
// transaction. The block accepts an item only when its sequencer is idle and
// hands each result to an output register that holds it until the receiver
// takes it; a stalled receiver lets the block finish one more item and then
// keeps it from taking the next.
// A clear or refused item goes straight to the output state. An append walks
// the suffix links from the last node, reading text and node length at each,
// then reads the edge for its symbol; a found node has its occurrence count
// read and updated, and a new node takes a second walk for its suffix link
// before its entries are written. No new item is taken until the last result
// is in the output register. Reset and clear restore the two roots at once,
// with no clearing pass: root edge bits live in flip-flops and every other
// node's entries are written when that node is created.
module palindromic_tree_builder #(
  parameter int MAX_LEN  = ptb_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = ptb_pkg::ALPHABET_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  ptb_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_ready,
  output ptb_pkg::result_t result
);

  localparam int OW       = ptb_pkg::OUT_W;
  localparam int NODE_CAP = MAX_LEN + 2;
  localparam int NW       = $clog2(NODE_CAP);
  localparam int TW       = $clog2(MAX_LEN + 1);
  localparam int LW       = TW + 1;
  localparam int EDEPTH   = NODE_CAP * ALPHABET;
  localparam int EAW      = $clog2(EDEPTH);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_WLEN  = 12'b000000000010,
    S_WCHK  = 12'b000000000100,
    S_WCMP  = 12'b000000001000,
    S_ERD   = 12'b000000010000,
    S_EUSE  = 12'b000000100000,
    S_FRD   = 12'b000001000000,
    S_FUSE  = 12'b000010000000,
    S_NWR   = 12'b000100000000,
    S_ORD   = 12'b001000000000,
    S_OWR   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;

  logic [ptb_pkg::SYM_W-1:0] text_mem [MAX_LEN+1];
  logic signed [LW-1:0]      len_mem  [NODE_CAP];
  logic [NW-1:0]             link_mem [NODE_CAP];
  logic [OW-1:0]             occ_mem  [NODE_CAP];
  logic [OW-1:0]             dep_mem  [NODE_CAP];
  logic [OW-1:0]             stp_mem  [NODE_CAP];
  logic [NW-1:0]             ser_mem  [NODE_CAP];
  logic [NW-1:0]             edge_mem [EDEPTH];
  logic [ALPHABET-1:0]       ev_mem   [NODE_CAP];

  logic                      t_we;
  logic [TW-1:0]             t_wa, t_ra;
  logic [ptb_pkg::SYM_W-1:0] t_rd;
  logic [NW-1:0]             n_wa, n_ra;
  logic                      n_we, occ_we;
  logic [OW-1:0]             occ_wd;
  logic signed [LW-1:0]      len_rd;
  logic [NW-1:0]             link_rd, ser_rd;
  logic [OW-1:0]             occ_rd, dep_rd, stp_rd;
  logic                      e_we;
  logic [EAW-1:0]            e_wa, e_ra;
  logic [NW-1:0]             e_rd;
  logic                      v_we;
  logic [NW-1:0]             v_wa, v_ra;
  logic [ALPHABET-1:0]       v_wd, v_rd;

  logic [TW-1:0]             tl;
  logic [NW-1:0]             nc, last, wx, wlnk, now, now_link, xn, fx, fnode, cur;
  logic signed [LW-1:0]      wlen, now_len, xlen;
  logic                      wp;
  logic [ALPHABET-1:0]       root_ev [2];
  logic [ALPHABET-1:0]       ev_now;
  logic [ptb_pkg::SYM_W-1:0] sym;
  ptb_pkg::result_t          res;

  logic                      accept, refuse;
  logic signed [LW-1:0]      len_c;
  logic [NW-1:0]             lnk_c;
  logic signed [LW:0]        pos;
  logic                      hit;
  logic [NW-1:0]             hit_node, hit_lnk;
  logic signed [LW-1:0]      hit_len;
  logic [ALPHABET-1:0]       row, sym_bit;
  logic [NW-1:0]             e_val;
  logic signed [LW-1:0]      lf;
  logic [OW-1:0]             df, sf, step_x;
  logic [NW-1:0]             srf, ser_x;
  logic signed [LW:0]        diff;

  assign item_ready   = (state == S_IDLE);
  assign accept       = item_valid && item_ready;
  assign refuse       = (tl >= TW'(MAX_LEN)) || (32'(item.symbol) >= ALPHABET) ||
                        (32'(nc) >= NODE_CAP);
  assign sym_bit      = ALPHABET'(1) << sym;

  always_comb begin
    len_c = (wx == '0) ? '0 : len_rd;
    lnk_c = (wx == '0) ? NW'(1) : link_rd;
    pos   = $signed({2'b00, tl}) - (LW+1)'(len_c) - (LW+1)'(1);
    hit      = 1'b0;
    hit_node = wx;
    hit_len  = wlen;
    hit_lnk  = wlnk;
    if (state == S_WLEN && wx == NW'(1)) begin
      hit      = 1'b1;
      hit_len  = -LW'(1);
      hit_lnk  = '0;
    end else if (state == S_WCMP && t_rd == sym) begin
      hit = 1'b1;
    end
    row   = (fx < NW'(2)) ? root_ev[fx[0]] : v_rd;
    e_val = row[sym] ? e_rd : '0;
    lf    = (fnode == '0) ? '0 : len_rd;
    df    = (fnode == '0) ? '0 : dep_rd;
    sf    = (fnode == '0) ? '0 : stp_rd;
    srf   = (fnode == '0) ? '0 : ser_rd;
    diff  = (LW+1)'(xlen) - (LW+1)'(lf);
    step_x = OW'($unsigned(diff));
    ser_x  = (step_x == sf) ? srf : fnode;
  end

  always_comb begin
    t_we   = accept && item.kind == ptb_pkg::KIND_APPEND && !refuse;
    t_wa   = tl + TW'(1);
    t_ra   = pos[TW-1:0];
    n_ra   = wx;
    if (state == S_FRD) begin
      n_ra = fnode;
    end else if (state == S_ORD) begin
      n_ra = cur;
    end
    n_we   = (state == S_FUSE);
    occ_we = (state == S_FUSE) || (state == S_OWR);
    n_wa   = (state == S_OWR) ? cur : xn;
    occ_wd = (state == S_OWR) ? occ_rd + OW'(1) : OW'(1);
    e_ra   = EAW'(fx * ALPHABET) + EAW'(sym);
    e_we   = (state == S_FUSE);
    e_wa   = EAW'(now * ALPHABET) + EAW'(sym);
    v_ra   = fx;
    v_we   = (state == S_FUSE) || (state == S_NWR && now >= NW'(2));
    v_wa   = (state == S_FUSE) ? xn : now;
    v_wd   = (state == S_FUSE) ? '0 : (ev_now | sym_bit);
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      text_mem[t_wa] <= item.symbol;
    end
    t_rd <= text_mem[t_ra];
    if (n_we) begin
      len_mem[n_wa]  <= xlen;
      link_mem[n_wa] <= fnode;
      dep_mem[n_wa]  <= df + OW'(1);
      stp_mem[n_wa]  <= step_x;
      ser_mem[n_wa]  <= ser_x;
    end
    if (occ_we) begin
      occ_mem[n_wa] <= occ_wd;
    end
    len_rd  <= len_mem[n_ra];
    link_rd <= link_mem[n_ra];
    occ_rd  <= occ_mem[n_ra];
    dep_rd  <= dep_mem[n_ra];
    stp_rd  <= stp_mem[n_ra];
    ser_rd  <= ser_mem[n_ra];
    if (e_we) begin
      edge_mem[e_wa] <= xn;
    end
    e_rd <= edge_mem[e_ra];
    if (v_we) begin
      ev_mem[v_wa] <= v_wd;
    end
    v_rd <= ev_mem[v_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tl           <= '0;
      nc           <= NW'(2);
      last         <= '0;
      root_ev[0]   <= '0;
      root_ev[1]   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sym <= item.symbol;
            if (item.kind == ptb_pkg::KIND_CLEAR) begin
              res        <= '0;
              tl         <= '0;
              nc         <= NW'(2);
              last       <= '0;
              root_ev[0] <= '0;
              root_ev[1] <= '0;
              state      <= S_OUT;
            end else if (refuse) begin
              res   <= '{refused: 1'b1, default: '0};
              state <= S_OUT;
            end else begin
              res   <= '0;
              tl    <= tl + TW'(1);
              wx    <= last;
              wp    <= 1'b0;
              state <= S_WLEN;
            end
          end
        end
        S_WLEN, S_WCHK, S_WCMP: begin
          if (hit) begin
            fx <= hit_node;
            if (!wp) begin
              now      <= hit_node;
              now_len  <= hit_len;
              now_link <= hit_lnk;
            end
            state <= S_ERD;
          end else if (state == S_WLEN) begin
            state <= S_WCHK;
          end else if (state == S_WCHK) begin
            wlen <= len_c;
            wlnk <= lnk_c;
            if (pos > 0) begin
              state <= S_WCMP;
            end else begin
              wx    <= lnk_c;
              state <= S_WLEN;
            end
          end else begin
            wx    <= wlnk;
            state <= S_WLEN;
          end
        end
        S_ERD: begin
          state <= S_EUSE;
        end
        S_EUSE: begin
          if (!wp) begin
            ev_now <= row;
            if (e_val != '0) begin
              cur   <= e_val;
              state <= S_ORD;
            end else begin
              xn    <= nc;
              nc    <= nc + NW'(1);
              xlen  <= now_len + LW'(2);
              wx    <= now_link;
              wp    <= 1'b1;
              state <= S_WLEN;
            end
          end else begin
            fnode <= e_val;
            state <= S_FRD;
          end
        end
        S_FRD: begin
          state <= S_FUSE;
        end
        S_FUSE: begin
          last             <= xn;
          res.suffix_node  <= OW'(xn);
          res.pal_length   <= OW'($unsigned(xlen));
          res.is_new       <= 1'b1;
          res.end_count    <= OW'(1);
          res.suffix_depth <= df + OW'(1);
          res.length_step  <= step_x;
          res.series_node  <= OW'(ser_x);
          state            <= S_NWR;
        end
        S_NWR: begin
          if (now < NW'(2)) begin
            root_ev[now[0]] <= ev_now | sym_bit;
          end
          state <= S_OUT;
        end
        S_ORD: begin
          state <= S_OWR;
        end
        S_OWR: begin
          last             <= cur;
          res.suffix_node  <= OW'(cur);
          res.pal_length   <= OW'($unsigned(len_rd));
          res.end_count    <= occ_rd + OW'(1);
          res.suffix_depth <= dep_rd;
          res.length_step  <= stp_rd;
          res.series_node  <= OW'(ser_rd);
          state            <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || result_ready) begin
            result <= res;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
